FILE: design/sdma_pkg.sv
`default_nettype none
package sdma_pkg;

    // Address and length register width
    localparam int ADDR_W = 20;

    // Request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_READ  = 2'd2
    } req_type_t;

    // Register ports
    localparam logic [7:0] PORT_SRC_LO  = 8'h4A;
    localparam logic [7:0] PORT_SRC_MID = 8'h4B;
    localparam logic [7:0] PORT_SRC_HI  = 8'h4C;
    localparam logic [7:0] PORT_LEN_LO  = 8'h4E;
    localparam logic [7:0] PORT_LEN_MID = 8'h4F;
    localparam logic [7:0] PORT_LEN_HI  = 8'h50;
    localparam logic [7:0] PORT_CTL     = 8'h52;

    // Control byte bits
    localparam int CTL_ENABLE_BIT = 7;
    localparam int CTL_DOWN_BIT   = 6;
    localparam int CTL_HYPER_BIT  = 4;
    localparam int CTL_RELOAD_BIT = 3;
    localparam logic [7:0] CTL_WRITE_MASK = 8'hDF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] reg_port;
        logic [7:0] write_value;
    } req_item_t;

    typedef struct packed {
        logic [7:0]        read_data;
        logic              fetch_valid;
        logic [ADDR_W-1:0] fetch_address;
        logic              fetch_target;
        logic              channel_active;
    } rsp_item_t;

    // Pacing timer load value after a fetch, by rate code
    function automatic logic [2:0] rate_reload(input logic [1:0] rate);
        logic [2:0] val;
        case (rate)
            2'd0:    val = 3'd5;
            2'd1:    val = 3'd3;
            2'd2:    val = 3'd1;
            default: val = 3'd0;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

FILE: design/sdma_in_stage.sv
`default_nettype none
module sdma_in_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  sdma_pkg::req_item_t req_item,
    input  wire                 advance,
    output logic                held_valid,
    output sdma_pkg::req_item_t held_item
);
    import sdma_pkg::*;

    logic      vld_reg, vld_next;
    req_item_t item_reg;
    logic      accept;

    // Stall only when a held transaction cannot move on this cycle
    assign req_stall = vld_reg && !advance;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (advance)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= req_item;
    end

    assign held_valid = vld_reg;
    assign held_item  = item_reg;
endmodule
`default_nettype wire

FILE: design/sdma_core.sv
`default_nettype none
module sdma_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 advance,
    input  sdma_pkg::req_item_t item,
    output sdma_pkg::rsp_item_t result
);
    import sdma_pkg::*;

    logic [ADDR_W-1:0] src_reg, src_next;
    logic [ADDR_W-1:0] src_rld_reg, src_rld_next;
    logic [ADDR_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] len_rld_reg, len_rld_next;
    logic [7:0]        ctl_reg, ctl_next;
    logic [2:0]        timer_reg, timer_next;

    logic [ADDR_W-1:0] len_dec;
    logic [7:0]        rd;
    logic              fv, ft;
    logic [ADDR_W-1:0] fa;

    assign len_dec = len_reg - 1'b1;

    // Next state and result for one transaction
    always_comb
    begin
        src_next     = src_reg;
        src_rld_next = src_rld_reg;
        len_next     = len_reg;
        len_rld_next = len_rld_reg;
        ctl_next     = ctl_reg;
        timer_next   = timer_reg;
        rd = 8'h00;
        fv = 1'b0;
        fa = '0;
        ft = 1'b0;
        case (item.req_type)
            REQ_WRITE:
            begin
                case (item.reg_port)
                    PORT_SRC_LO:
                    begin
                        src_next     = {src_reg[19:8], item.write_value};
                        src_rld_next = src_next;
                    end
                    PORT_SRC_MID:
                    begin
                        src_next     = {src_reg[19:16], item.write_value, src_reg[7:0]};
                        src_rld_next = src_next;
                    end
                    PORT_SRC_HI:
                    begin
                        src_next     = {item.write_value[3:0], src_reg[15:0]};
                        src_rld_next = src_next;
                    end
                    PORT_LEN_LO:
                    begin
                        len_next     = {len_reg[19:8], item.write_value};
                        len_rld_next = len_next;
                    end
                    PORT_LEN_MID:
                    begin
                        len_next     = {len_reg[19:16], item.write_value, len_reg[7:0]};
                        len_rld_next = len_next;
                    end
                    PORT_LEN_HI:
                    begin
                        len_next     = {item.write_value[3:0], len_reg[15:0]};
                        len_rld_next = len_next;
                    end
                    PORT_CTL:
                        ctl_next = item.write_value & CTL_WRITE_MASK;
                    default: ;
                endcase
            end
            REQ_READ:
            begin
                case (item.reg_port)
                    PORT_SRC_LO:  rd = src_reg[7:0];
                    PORT_SRC_MID: rd = src_reg[15:8];
                    PORT_SRC_HI:  rd = {4'h0, src_reg[19:16]};
                    PORT_LEN_LO:  rd = len_reg[7:0];
                    PORT_LEN_MID: rd = len_reg[15:8];
                    PORT_LEN_HI:  rd = {4'h0, len_reg[19:16]};
                    PORT_CTL:     rd = ctl_reg;
                    default:      rd = 8'h00;
                endcase
            end
            REQ_TICK:
            begin
                if (ctl_reg[CTL_ENABLE_BIT])
                begin
                    if (timer_reg == 3'd0)
                    begin
                        // Fetch one byte, step source, count length; at the end reload or stop
                        fv = 1'b1;
                        fa = src_reg;
                        ft = ctl_reg[CTL_HYPER_BIT];
                        if (ctl_reg[CTL_DOWN_BIT])
                            src_next = src_reg - 1'b1;
                        else
                            src_next = src_reg + 1'b1;
                        len_next = len_dec;
                        if (len_dec == '0)
                        begin
                            if (ctl_reg[CTL_RELOAD_BIT])
                            begin
                                len_next = len_rld_reg;
                                src_next = src_rld_reg;
                            end
                            else
                                ctl_next[CTL_ENABLE_BIT] = 1'b0;
                        end
                        timer_next = rate_reload(ctl_reg[1:0]);
                    end
                    else
                        timer_next = timer_reg - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg     <= '0;
            src_rld_reg <= '0;
            len_reg     <= '0;
            len_rld_reg <= '0;
            ctl_reg     <= 8'h00;
            timer_reg   <= 3'd0;
        end
        else if (advance)
        begin
            src_reg     <= src_next;
            src_rld_reg <= src_rld_next;
            len_reg     <= len_next;
            len_rld_reg <= len_rld_next;
            ctl_reg     <= ctl_next;
            timer_reg   <= timer_next;
        end
    end

    assign result.read_data      = rd;
    assign result.fetch_valid    = fv;
    assign result.fetch_address  = fa;
    assign result.fetch_target   = ft;
    assign result.channel_active = ctl_next[CTL_ENABLE_BIT];
endmodule
`default_nettype wire

FILE: design/sdma_out_stage.sv
`default_nettype none
module sdma_out_stage (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  sdma_pkg::rsp_item_t result,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output sdma_pkg::rsp_item_t rsp_item
);
    import sdma_pkg::*;

    logic      vld_reg, vld_next;
    rsp_item_t item_reg;

    // Hold until the consumer takes the transaction
    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (!rsp_stall)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= result;
    end

    assign rsp_valid = vld_reg;
    assign rsp_item  = item_reg;
endmodule
`default_nettype wire

FILE: design/sound_sample_dma_channel.sv
`default_nettype none
// Channel | Handshake           | Payload
// req     | req_valid/req_stall | req_item (req_type, reg_port, write_value)
// rsp     | rsp_valid/rsp_stall | rsp_item (read_data, fetch_*, channel_active)
//
// One transaction per cycle sustained while rsp is not stalled; a transaction
// passes the input register, then register update logic into the result register,
// before rsp_valid rises for it.
// Reset (async, active low) clears all channel registers and the valid flags of both stages.
// A stall on rsp holds the result; req stalls only when the input register
// holds a transaction that cannot move into the occupied result register.
module sound_sample_dma_channel (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  sdma_pkg::req_item_t req_item,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output sdma_pkg::rsp_item_t rsp_item
);
    import sdma_pkg::*;

    logic      held_valid;
    req_item_t held_item;
    rsp_item_t result;
    logic      advance;

    // Move the held transaction when the result register is free or draining
    assign advance = held_valid && (!rsp_valid || !rsp_stall);

    sdma_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sdma_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (held_item),
        .result  (result)
    );

    sdma_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .result    (result),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );
endmodule
`default_nettype wire
